// ----- design/weighted_server_task_assigner_defines.svh -----
// Assertion macros shared by the server task assigner RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef WEIGHTED_SERVER_TASK_ASSIGNER_DEFINES_SVH
`define WEIGHTED_SERVER_TASK_ASSIGNER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define WSTA_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define WSTA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/wsta_pkg.sv -----
// Types and constants for the server task assigner.
// No dependencies; used by wsta_pick and weighted_server_task_assigner.
package wsta_pkg;

    localparam int MINUTE_W        = 48;
    localparam int CFG_W           = 5;
    localparam int SLOT_W          = 4;
    localparam int IN_WEIGHT_W     = 16;
    localparam int DURATION_W      = 16;
    localparam int DEF_NUM_SERVERS = 16;
    localparam int DEF_WEIGHT_BITS = 16;

    localparam logic [MINUTE_W-1:0] MINUTE_MAX = {MINUTE_W{1'b1}};
    localparam logic [CFG_W-1:0]    CFG_RESET  = CFG_W'(16);

    // Item modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_JOB  = 1'b1;

    typedef struct packed {
        logic                   mode;
        logic [SLOT_W-1:0]      server_slot;
        logic [IN_WEIGHT_W-1:0] weight;
        logic [DURATION_W-1:0]  duration;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   server_index;
        logic [MINUTE_W-1:0] start_minute;
        logic [MINUTE_W-1:0] busy_until;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

// ----- design/weighted_server_task_assigner.sv -----
// Load items leave the block in idle, so they may follow back to back.
// After a job transfers, the scan reads one table entry per active server through a shared
// compare unit behind one read pipe register, and a finish state then registers the result.
// The next item is taken only once the block is back in idle after the finish state, which
// waits there while the previous result has not yet left on m_ready.
// Synchronous active-low reset clears valid bits, minutes and job count; servers_in_use -> 16.
`include "weighted_server_task_assigner_defines.svh"

module weighted_server_task_assigner #(
    parameter int NUM_SERVERS = wsta_pkg::DEF_NUM_SERVERS,
    parameter int WEIGHT_BITS = wsta_pkg::DEF_WEIGHT_BITS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [wsta_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  wsta_pkg::in_item_t         s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output wsta_pkg::out_item_t        m_data
);
    import wsta_pkg::*;

    localparam int IDX_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
    localparam int CNT_W = $clog2(NUM_SERVERS + 1);

    state_t state_reg, state_next;

    logic [CFG_W-1:0] cfg_reg;
    logic [CNT_W-1:0] active;

    // Server tables
    logic [WEIGHT_BITS-1:0] weight_mem [NUM_SERVERS];
    logic [MINUTE_W-1:0]    free_mem   [NUM_SERVERS];
    logic [NUM_SERVERS-1:0] wvalid_reg;
    logic [NUM_SERVERS-1:0] fvalid_reg;

    // Scan read pipe
    logic [IDX_W-1:0]       rd_idx_reg;
    logic                   issue_reg;
    logic [WEIGHT_BITS-1:0] rd_wt_reg;
    logic [MINUTE_W-1:0]    rd_free_reg;
    logic                   rd_wvld_reg;
    logic                   rd_fvld_reg;
    logic                   pipe_vld_reg;
    logic                   pipe_last_reg;
    logic [IDX_W-1:0]       pipe_idx_reg;
    logic                   last_issue;

    // Job state
    logic [MINUTE_W-1:0]   now0_reg;
    logic [DURATION_W-1:0] dur_reg;
    logic [MINUTE_W-1:0]   cur_minute_reg;
    logic [MINUTE_W-1:0]   jobs_seen_reg;

    logic      m_valid_reg;
    out_item_t m_data_reg;

    logic                 s_fire, load_fire, job_start, slot_ok;
    logic [IDX_W-1:0]     slot_addr;
    logic                 out_free, finish_fire;
    logic [MINUTE_W-1:0]  now_sel;
    logic [IDX_W-1:0]     best_sel;
    logic [MINUTE_W:0]    busy_sum;
    logic [MINUTE_W-1:0]  busy_until;
    logic [WEIGHT_BITS-1:0] entry_weight;
    logic [MINUTE_W-1:0]    entry_free;

    // Clamp servers_in_use to the table size
    always_comb begin
        if (32'(cfg_reg) > NUM_SERVERS) begin
            active = CNT_W'(NUM_SERVERS);
        end else begin
            active = CNT_W'(cfg_reg);
        end
    end

    // Transfer decode
    assign s_fire      = s_valid && s_ready;
    assign load_fire   = s_fire && (s_data.mode == MODE_LOAD);
    assign job_start   = s_fire && (s_data.mode == MODE_JOB) && (active != '0);
    assign slot_ok     = 32'(s_data.server_slot) < NUM_SERVERS;
    assign slot_addr   = IDX_W'(s_data.server_slot);
    assign out_free    = !m_valid_reg || m_ready;
    assign last_issue  = CNT_W'(CNT_W'(rd_idx_reg) + CNT_W'(1)) == active;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (job_start) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (pipe_vld_reg && pipe_last_reg) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        s_ready     = (state_reg == ST_IDLE);
        finish_fire = (state_reg == ST_FINISH) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_wr_en) begin
            cfg_reg <= cfg_wr_data;
        end
    end

    // Weight table
    always_ff @(posedge aclk) begin
        if (load_fire && slot_ok) begin
            weight_mem[slot_addr] <= WEIGHT_BITS'(s_data.weight);
        end
        rd_wt_reg <= weight_mem[rd_idx_reg];
    end

    // Free-minute table
    always_ff @(posedge aclk) begin
        if (load_fire && slot_ok) begin
            free_mem[slot_addr] <= '0;
        end else if (finish_fire) begin
            free_mem[best_sel] <= busy_until;
        end
        rd_free_reg <= free_mem[rd_idx_reg];
    end

    // Entry valid bits; unwritten entries read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wvalid_reg <= '0;
            fvalid_reg <= '0;
        end else if (load_fire && slot_ok) begin
            wvalid_reg[slot_addr] <= 1'b1;
            fvalid_reg[slot_addr] <= 1'b1;
        end else if (finish_fire) begin
            fvalid_reg[best_sel] <= 1'b1;
        end
    end

    // Scan address sequencer and read pipe control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg    <= 1'b0;
            pipe_vld_reg <= 1'b0;
        end else begin
            pipe_vld_reg <= (state_reg == ST_SCAN) && issue_reg;
            if (job_start) begin
                issue_reg <= 1'b1;
            end else if ((state_reg == ST_SCAN) && issue_reg && last_issue) begin
                issue_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (job_start) begin
            rd_idx_reg <= '0;
        end else if ((state_reg == ST_SCAN) && issue_reg && !last_issue) begin
            rd_idx_reg <= IDX_W'(rd_idx_reg + IDX_W'(1));
        end
        pipe_idx_reg  <= rd_idx_reg;
        pipe_last_reg <= last_issue;
        rd_wvld_reg   <= wvalid_reg[rd_idx_reg];
        rd_fvld_reg   <= fvalid_reg[rd_idx_reg];
    end

    assign entry_weight = rd_wvld_reg ? rd_wt_reg : '0;
    assign entry_free   = rd_fvld_reg ? rd_free_reg : '0;

    // Arrival minute and duration latched at job transfer
    always_ff @(posedge aclk) begin
        if (job_start) begin
            now0_reg <= (cur_minute_reg >= jobs_seen_reg) ? cur_minute_reg : jobs_seen_reg;
            dur_reg  <= s_data.duration;
        end
    end

    wsta_pick #(
        .IDX_W       (IDX_W),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_pick (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .clear        (job_start),
        .step         (pipe_vld_reg),
        .entry_idx    (pipe_idx_reg),
        .entry_weight (entry_weight),
        .entry_free   (entry_free),
        .now0         (now0_reg),
        .now_sel      (now_sel),
        .best_sel     (best_sel)
    );

    // Saturating busy-until
    always_comb begin
        busy_sum   = (MINUTE_W+1)'(now_sel) + (MINUTE_W+1)'(dur_reg);
        busy_until = busy_sum[MINUTE_W] ? MINUTE_MAX : busy_sum[MINUTE_W-1:0];
    end

    // Minute and job counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_minute_reg <= '0;
            jobs_seen_reg  <= '0;
        end else if (finish_fire) begin
            cur_minute_reg <= now_sel;
            if (jobs_seen_reg != MINUTE_MAX) begin
                jobs_seen_reg <= jobs_seen_reg + MINUTE_W'(1);
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (finish_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish_fire) begin
            m_data_reg.server_index <= SLOT_W'(best_sel);
            m_data_reg.start_minute <= now_sel;
            m_data_reg.busy_until   <= busy_until;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks
    `WSTA_ASSERT_SAME(a_pick_in_range, aclk, aresetn, state_reg == ST_FINISH, CNT_W'(best_sel) < active, "picked server outside active range")
    `WSTA_ASSERT_NEXT(a_minute_tracks_result, aclk, aresetn, finish_fire, cur_minute_reg == m_data.start_minute, "current minute does not match issued start")
    `WSTA_ASSERT_SAME(a_busy_not_before_start, aclk, aresetn, m_valid, m_data.busy_until >= m_data.start_minute, "busy_until precedes start_minute")
    `WSTA_ASSERT_SAME(a_start_not_before_arrival, aclk, aresetn, state_reg == ST_FINISH, now_sel >= now0_reg, "start minute earlier than arrival")

endmodule

// ----- design/wsta_pick.sv -----
// Shared compare unit: walks server entries one per cycle and tracks the winner.
// Depends on wsta_pkg for the minute width.
module wsta_pick #(
    parameter int IDX_W       = 4,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          clear,
    input  logic                          step,
    input  logic [IDX_W-1:0]              entry_idx,
    input  logic [WEIGHT_BITS-1:0]        entry_weight,
    input  logic [wsta_pkg::MINUTE_W-1:0] entry_free,
    input  logic [wsta_pkg::MINUTE_W-1:0] now0,
    output logic [wsta_pkg::MINUTE_W-1:0] now_sel,
    output logic [IDX_W-1:0]              best_sel
);
    import wsta_pkg::*;

    // Tracker A: best weight among servers free by the arrival minute
    logic                   found_a_reg;
    logic [IDX_W-1:0]       best_a_reg;
    logic [WEIGHT_BITS-1:0] wa_reg;
    // Tracker B: best weight among servers sharing the earliest free minute
    logic                   found_b_reg;
    logic [IDX_W-1:0]       best_b_reg;
    logic [WEIGHT_BITS-1:0] wb_reg;
    logic [MINUTE_W-1:0]    minf_reg;

    logic take_a;
    logic new_min;
    logic take_b_tie;

    // Compare stage
    always_comb begin
        take_a     = (entry_free <= now0) && (!found_a_reg || (entry_weight < wa_reg));
        new_min    = !found_b_reg || (entry_free < minf_reg);
        take_b_tie = found_b_reg && (entry_free == minf_reg) && (entry_weight < wb_reg);
    end

    // Control flags
    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            found_a_reg <= 1'b0;
            found_b_reg <= 1'b0;
        end else if (step) begin
            if (take_a) begin
                found_a_reg <= 1'b1;
            end
            found_b_reg <= 1'b1;
        end
    end

    // Tracked values
    always_ff @(posedge aclk) begin
        if (step) begin
            if (take_a) begin
                best_a_reg <= entry_idx;
                wa_reg     <= entry_weight;
            end
            if (new_min) begin
                minf_reg   <= entry_free;
                best_b_reg <= entry_idx;
                wb_reg     <= entry_weight;
            end else if (take_b_tie) begin
                best_b_reg <= entry_idx;
                wb_reg     <= entry_weight;
            end
        end
    end

    // If someone is free at arrival, minute stays; else jump to earliest free
    assign now_sel  = found_a_reg ? now0 : minf_reg;
    assign best_sel = found_a_reg ? best_a_reg : best_b_reg;

endmodule

// ----- verif/weighted_server_task_assigner_tb.sv -----
// Self-checking testbench for weighted_server_task_assigner: directed table, then random
// loads and jobs over several pool sizes, with random idling and a long output hold-off.
// Depends on wsta_pkg and the weighted_server_task_assigner RTL.
module weighted_server_task_assigner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wsta_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;       // long output hold-off
    localparam int IDLE_PCT      = 34;
    localparam int LIMIT_NS      = 1_000_000;
    localparam int NUM_PHASES    = 7;
    localparam int POOL_PLAN  [NUM_PHASES] = '{1, 0, 31, 3, 17, 16, 8};
    localparam int ITEM_PLAN  [NUM_PHASES] = '{70, 20, 70, 70, 60, 90, 60};
    localparam int HOLD_PHASE  = 2;           // receiver holds off at start
    localparam int PAUSE_PHASE = 3;           // sender drains halfway through
    localparam int CALM_PHASE  = 5;           // no idling on either side

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t want;
    } plan_row_t;

    logic      aclk;
    logic      aresetn;
    logic      cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    // Predictor state
    logic [IN_WEIGHT_W-1:0] srv_weight [DEF_NUM_SERVERS];
    logic [MINUTE_W-1:0]    srv_free   [DEF_NUM_SERVERS];
    logic [MINUTE_W-1:0]    now_minute;
    logic [MINUTE_W-1:0]    arrival_minute;
    logic [CFG_W-1:0]       pool_size;

    out_item_t assign_q [$];
    plan_row_t plan [$];
    out_item_t head;
    int        err_count = 0;
    bit        calm      = 1'b0;
    bit        hold_req  = 1'b0;

    weighted_server_task_assigner i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic void flag_error(string msg);
        err_count++;
        if (err_count <= 10) $display("ERROR: %s", msg);
    endfunction

    // Update the server tables for one accepted item; returns 1 if a job gets assigned.
    function automatic bit predict_item(input in_item_t it, output out_item_t res);
        int n;
        int pick;
        bit found;
        logic [MINUTE_W-1:0] at_minute;
        logic [MINUTE_W-1:0] first_free;
        logic [MINUTE_W:0]   sum;
        res = '0;
        if (it.mode == MODE_LOAD) begin
            srv_weight[it.server_slot] = it.weight;
            srv_free[it.server_slot]   = '0;
            return 1'b0;
        end
        n = (pool_size > DEF_NUM_SERVERS) ? DEF_NUM_SERVERS : int'(pool_size);
        if (n == 0) return 1'b0;   // empty pool drops the job, nothing advances

        at_minute = (arrival_minute > now_minute) ? arrival_minute : now_minute;
        first_free = srv_free[0];
        for (int i = 1; i < n; i++)
            if (srv_free[i] < first_free) first_free = srv_free[i];
        if (first_free > at_minute) at_minute = first_free;

        // lightest free server, lowest index on ties
        pick  = 0;
        found = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (srv_free[i] <= at_minute && (!found || srv_weight[i] < srv_weight[pick])) begin
                pick  = i;
                found = 1'b1;
            end
        end

        now_minute = at_minute;
        sum = {1'b0, at_minute} + it.duration;
        srv_free[pick] = (sum > MINUTE_MAX) ? MINUTE_MAX : sum[MINUTE_W-1:0];
        if (arrival_minute != MINUTE_MAX) arrival_minute++;

        res.server_index = pick[SLOT_W-1:0];
        res.start_minute = at_minute;
        res.busy_until   = srv_free[pick];
        return 1'b1;
    endfunction

    function automatic plan_row_t row(logic mode, int slot, int wt, int dur,
                                      bit typed = 1'b0, int idx = 0,
                                      longint unsigned at = 0, longint unsigned busy = 0);
        plan_row_t r;
        r.item  = '{mode, SLOT_W'(slot), IN_WEIGHT_W'(wt), DURATION_W'(dur)};
        r.typed = typed;
        r.want  = '{SLOT_W'(idx), MINUTE_W'(at), MINUTE_W'(busy)};
        return r;
    endfunction

    function automatic in_item_t rand_item();
        in_item_t it;
        int sel;
        it.mode        = ($urandom_range(0, 99) < 70) ? MODE_JOB : MODE_LOAD;
        it.server_slot = SLOT_W'($urandom_range(0, 15));
        sel = $urandom_range(0, 9);
        if (sel < 6)      it.weight = IN_WEIGHT_W'($urandom_range(0, 7));   // many ties
        else if (sel < 8) it.weight = IN_WEIGHT_W'($urandom_range(0, 65535));
        else              it.weight = (sel == 8) ? '0 : '1;
        sel = $urandom_range(0, 9);
        if (sel < 6)      it.duration = DURATION_W'($urandom_range(0, 30));
        else if (sel < 8) it.duration = DURATION_W'($urandom_range(0, 1000));
        else if (sel < 9) it.duration = DURATION_W'($urandom_range(0, 65535));
        else              it.duration = '1;
        return it;
    endfunction

    // Offer one item after a random gap; predict it once the transfer happens.
    task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
        out_item_t res;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        if (predict_item(it, res)) assign_q.push_back(typed ? want : res);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (assign_q.size() != 0) @(posedge aclk);
    endtask

    // Pool size changes only with the block idle
    task automatic set_pool(input int value);
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CFG_W'(value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        pool_size = CFG_W'(value);
    endtask

    // Result sink: random back-pressure plus one long hold-off on request
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Compare each result transfer with the oldest expected assignment
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (assign_q.size() == 0) begin
                flag_error($sformatf("unexpected result idx=%0d start=%0d busy=%0d",
                                     m_data.server_index, m_data.start_minute,
                                     m_data.busy_until));
            end else begin
                head = assign_q.pop_front();
                if (m_data.server_index !== head.server_index)
                    flag_error($sformatf("server_index expected %0d got %0d",
                                         head.server_index, m_data.server_index));
                if (m_data.start_minute !== head.start_minute)
                    flag_error($sformatf("start_minute expected %0d got %0d",
                                         head.start_minute, m_data.start_minute));
                if (m_data.busy_until !== head.busy_until)
                    flag_error($sformatf("busy_until expected %0d got %0d",
                                         head.busy_until, m_data.busy_until));
            end
        end
    end

    initial begin
        #LIMIT_NS;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_data      <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        for (int i = 0; i < DEF_NUM_SERVERS; i++) begin
            srv_weight[i] = '0;
            srv_free[i]   = '0;
        end
        now_minute     = '0;
        arrival_minute = '0;
        pool_size      = CFG_RESET;

        // Directed table, pool at its reset size of 16
        plan.push_back(row(MODE_JOB,   0, 16'h0000, 5,        1, 0, 0, 5));
        plan.push_back(row(MODE_JOB,  15, 16'hFFFF, 0,        1, 1, 1, 1));
        plan.push_back(row(MODE_LOAD,  0, 16'hFFFF, 16'hFFFF));  // reload frees server 0
        plan.push_back(row(MODE_LOAD, 15, 16'h0000, 0));
        plan.push_back(row(MODE_JOB,  15, 16'hFFFF, 16'hFFFF, 1, 1, 2, 65537));
        plan.push_back(row(MODE_LOAD,  1, 3, 0));
        plan.push_back(row(MODE_LOAD,  2, 1, 0));
        plan.push_back(row(MODE_LOAD,  3, 1, 0));
        plan.push_back(row(MODE_LOAD,  4, 16'h8000, 0));
        for (int i = 0; i < 12; i++)
            plan.push_back(row(MODE_JOB, 10, 16'h5555, 1000));
        plan.push_back(row(MODE_LOAD,  8, 7, 16'hAAAA));  // busy server released by reload
        plan.push_back(row(MODE_JOB,   0, 0, 0));
        plan.push_back(row(MODE_JOB,   0, 0, 2));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) send_item(plan[i].item, plan[i].typed, plan[i].want);

        // Random part over several pool sizes
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_pool(POOL_PLAN[p]);
            if (p == HOLD_PHASE) hold_req = 1'b1;
            calm = (p == CALM_PHASE);
            for (int k = 0; k < ITEM_PLAN[p]; k++) begin
                if (p == PAUSE_PHASE && k == ITEM_PLAN[p] / 2) drain();
                send_item(rand_item(), 1'b0, '0);
            end
        end
        calm = 1'b0;

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (err_count == 0 && assign_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
